/* rtl/core/job_queue_with_cancel_unit_assert.svh */
// ----------------------------------------------------------------------------
// job queue assertion macros
// shared property forms for the job queue checks, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef JOB_QUEUE_WITH_CANCEL_UNIT_ASSERT_SVH
`define JOB_QUEUE_WITH_CANCEL_UNIT_ASSERT_SVH

// condition that holds at every edge
`define JQC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("job queue check failed");

// same-cycle implication
`define JQC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job queue check failed");

// next-cycle implication
`define JQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job queue check failed");

`endif

/* rtl/core/jqc_pkg.sv */
// ----------------------------------------------------------------------------
// jqc_pkg
// sizes, codes, job record type and slot arithmetic for the job queue
// ----------------------------------------------------------------------------
package jqc_pkg;

  localparam int DEPTH     = 16;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_CONSUME = 3'd2;
  localparam logic [2:0] OP_LIST    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_BAD_POS   = 3'd3;
  localparam logic [2:0] STAT_BAD_PAGES = 3'd4;

  typedef struct packed {
    logic [63:0]          name;
    logic [31:0]          kind;
    logic [PAGE_BITS-1:0] pages;
  } job_t;

  // store slot of queue position k (0-based) from the head slot
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0]  k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return SLOT_W'(s);
  endfunction

endpackage

/* rtl/core/jqc_ram.sv */
// ----------------------------------------------------------------------------
// jqc_ram
// job record store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module jqc_ram import jqc_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  job_t              wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr,
  output job_t              rdata
);

  job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/job_queue_with_cancel_unit.sv */
// ----------------------------------------------------------------------------
// job_queue_with_cancel_unit
// Bounded job queue of 16 jobs (name, type tag, page count) kept in one
// record memory with a running job count and page total. One item is worked
// at a time; a result waits in an output register while the next item is
// taken. Insert, clear and every rejected item go straight to emit; consume
// reads the head record, then emits; cancel at position p reads that record,
// moves each later job one place forward, then emits; list gives one result
// per cycle once the first read returns, while the output is not stalled.
// Opcodes 5 to 7 are taken and give no result. Output stalls hold the unit.
// ----------------------------------------------------------------------------
module job_queue_with_cancel_unit import jqc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // job_name[63:0], job_type[95:64], page_count[111:96],
  // cancel_position[116:112], zero fill
  input  logic [119:0] s_tdata,
  // opcode[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_position[4:0], out_job_name[68:5], out_job_type[100:69],
  // out_page_count[116:101], queue_length[121:117], pages_total[141:122],
  // zero fill
  output logic [143:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  // last_result
  output logic         m_tlast
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CAP   = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_LIST  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [19:0]       psum, psum_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [2:0]        op, op_next;
  job_t              res, res_next;
  logic [2:0]        res_status, res_status_next;
  logic [4:0]        res_pos, res_pos_next;

  logic [2:0]        out_status;
  logic [4:0]        out_pos;
  job_t              out_job;
  logic [4:0]        out_len;
  logic [19:0]       out_total;
  logic              out_last;

  logic              load_out;
  logic [2:0]        ld_status;
  logic [4:0]        ld_pos;
  job_t              ld_job;
  logic              ld_last;

  logic              we, re;
  logic [SLOT_W-1:0] waddr, raddr;
  job_t              wdata, rdata;

  logic [2:0]           opcode;
  logic [4:0]           cancel_pos;
  logic [PAGE_BITS-1:0] page_in;
  job_t                 in_job;
  logic                 in_acc, slot_free, ins_ok;

  assign opcode       = s_tuser;
  assign cancel_pos   = s_tdata[116:112];
  assign page_in      = PAGE_BITS'(s_tdata[111:96]);
  assign in_job.name  = s_tdata[63:0];
  assign in_job.kind  = s_tdata[95:64];
  assign in_job.pages = page_in;

  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign ins_ok    = in_acc && (opcode == OP_INSERT) && (page_in != '0)
                     && (count != CNT_W'(DEPTH));

  jqc_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    psum_next       = psum;
    idx_next        = idx;
    op_next         = op;
    res_next        = res;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    we              = 1'b0;
    waddr           = slot_of(head, count);
    wdata           = in_job;
    re              = 1'b0;
    raddr           = head;
    load_out        = 1'b0;
    ld_status       = res_status;
    ld_pos          = res_pos;
    ld_job          = res;
    ld_last         = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          res_next        = '0;
          res_pos_next    = '0;
          res_status_next = STAT_EMPTY;
          op_next         = opcode;
          case (opcode)
            OP_INSERT: begin
              state_next = ST_EMIT;
              if (page_in == '0) begin
                res_status_next = STAT_BAD_PAGES;
              end else if (count == CNT_W'(DEPTH)) begin
                res_status_next = STAT_FULL;
              end else begin
                we              = 1'b1;
                count_next      = count + 1'b1;
                psum_next       = psum + 20'(page_in);
                res_next        = in_job;
                res_status_next = STAT_OK;
                res_pos_next    = 5'(count + 1'b1);
              end
            end
            OP_CANCEL: begin
              if (count == '0) begin
                state_next = ST_EMIT;
              end else if (cancel_pos == '0 || int'(cancel_pos) > int'(count)) begin
                res_status_next = STAT_BAD_POS;
                state_next      = ST_EMIT;
              end else begin
                re           = 1'b1;
                raddr        = slot_of(head, CNT_W'(cancel_pos - 5'd1));
                idx_next     = CNT_W'(cancel_pos - 5'd1);
                res_pos_next = cancel_pos;
                state_next   = ST_CAP;
              end
            end
            OP_CONSUME: begin
              if (count == '0) begin
                state_next = ST_EMIT;
              end else begin
                re           = 1'b1;
                raddr        = head;
                res_pos_next = 5'd1;
                state_next   = ST_CAP;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                state_next = ST_EMIT;
              end else begin
                re         = 1'b1;
                raddr      = head;
                idx_next   = '0;
                state_next = ST_LIST;
              end
            end
            OP_CLEAR: begin
              state_next = ST_EMIT;
              if (count != '0) begin
                count_next      = '0;
                psum_next       = '0;
                head_next       = '0;
                res_status_next = STAT_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CAP: begin
        res_next        = rdata;
        res_status_next = STAT_OK;
        psum_next       = psum - 20'(rdata.pages);
        if (op == OP_CONSUME) begin
          head_next  = (head == SLOT_W'(DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
          state_next = ST_EMIT;
        end else if (idx + 1'b1 < count) begin
          re         = 1'b1;
          raddr      = slot_of(head, idx + 1'b1);
          state_next = ST_SHIFT;
        end else begin
          count_next = count - 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        // close the gap: move the record read last cycle one place forward
        we       = 1'b1;
        waddr    = slot_of(head, idx);
        wdata    = rdata;
        idx_next = idx + 1'b1;
        if ((CNT_W+1)'(idx) + (CNT_W+1)'(2) < (CNT_W+1)'(count)) begin
          re    = 1'b1;
          raddr = slot_of(head, CNT_W'((CNT_W+1)'(idx) + (CNT_W+1)'(2)));
        end else begin
          count_next = count - 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_LIST: begin
        ld_status = STAT_OK;
        ld_pos    = 5'(idx + 1'b1);
        ld_job    = rdata;
        ld_last   = (idx + 1'b1 == count);
        if (slot_free) begin
          load_out = 1'b1;
          if (idx + 1'b1 == count) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            re       = 1'b1;
            raddr    = slot_of(head, idx + 1'b1);
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      psum     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      psum  <= psum_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    op         <= op_next;
    res        <= res_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (load_out) begin
      out_status <= ld_status;
      out_pos    <= ld_pos;
      out_job    <= ld_job;
      out_len    <= 5'(count_next);
      out_total  <= psum_next;
      out_last   <= ld_last;
    end
  end

  assign m_tdata = {2'b00, out_total, out_len, 16'(out_job.pages), out_job.kind,
                    out_job.name, out_pos};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

`include "job_queue_with_cancel_unit_assert.svh"

  `JQC_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `JQC_ASSERT_IMPL(a_load_slot_free, load_out, !m_tvalid || m_tready)
  `JQC_ASSERT_IMPL(a_shift_in_range, state == ST_SHIFT, idx + 1'b1 < count)
  `JQC_ASSERT_NEXT(a_insert_grows, ins_ok, count == $past(count) + 1'b1)

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for job_queue_with_cancel_unit. A built-in queue model
// predicts every result from each accepted item. Results are checked in order
// against it, with random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top import jqc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [2:0]           status;
    logic [4:0]           position;
    logic [63:0]          name;
    logic [31:0]          kind;
    logic [PAGE_BITS-1:0] pages;
    logic [4:0]           length;
    logic [19:0]          total;
    logic                 last;
  } job_report_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;   // job_name, job_type, page_count, cancel_position, zero fill
  logic [2:0]   s_tuser;   // opcode
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;   // entry_position, name, type, pages, length, total, zero fill
  logic [2:0]   m_tuser;   // status
  logic         m_tlast;

  job_queue_with_cancel_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // queue model
  logic [63:0]          slot_name  [DEPTH];
  logic [31:0]          slot_kind  [DEPTH];
  logic [PAGE_BITS-1:0] slot_pages [DEPTH];
  int                   head_ptr;
  int                   job_count;
  int                   page_total;

  job_report_t due_reports[$];
  int          error_count;
  bit          idle_on;
  int          hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("job_queue_with_cancel_unit regression: fail");
    $finish;
  end

  task automatic post_report(input job_report_t r);
    r.length = 5'(job_count);
    r.total  = 20'(page_total);
    due_reports.push_back(r);
  endtask

  task automatic apply_job_op(input logic [2:0] op, input logic [63:0] nm,
                              input logic [31:0] kd, input logic [15:0] pg_in,
                              input logic [4:0] pos);
    job_report_t          r;
    logic [PAGE_BITS-1:0] pg;
    int                   s;
    int                   d;
    int                   n;
    int                   k;
    pg = pg_in[PAGE_BITS-1:0];
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_INSERT: begin
        if (pg == '0) begin
          r.status = STAT_BAD_PAGES;
        end else if (job_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          s = (head_ptr + job_count) % DEPTH;
          slot_name[s]  = nm;
          slot_kind[s]  = kd;
          slot_pages[s] = pg;
          job_count++;
          page_total += int'(pg);
          r.status   = STAT_OK;
          r.position = 5'(job_count);
          r.name     = nm;
          r.kind     = kd;
          r.pages    = pg;
        end
        post_report(r);
      end
      OP_CANCEL: begin
        if (job_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos == 0 || int'(pos) > job_count) begin
          r.status = STAT_BAD_POS;
        end else begin
          s = (head_ptr + int'(pos) - 1) % DEPTH;
          r.status   = STAT_OK;
          r.position = pos;
          r.name     = slot_name[s];
          r.kind     = slot_kind[s];
          r.pages    = slot_pages[s];
          for (k = int'(pos) - 1; k + 1 < job_count; k++) begin
            d = (head_ptr + k) % DEPTH;
            n = (head_ptr + k + 1) % DEPTH;
            slot_name[d]  = slot_name[n];
            slot_kind[d]  = slot_kind[n];
            slot_pages[d] = slot_pages[n];
          end
          job_count--;
          page_total -= int'(r.pages);
        end
        post_report(r);
      end
      OP_CONSUME: begin
        if (job_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status   = STAT_OK;
          r.position = 5'd1;
          r.name     = slot_name[head_ptr];
          r.kind     = slot_kind[head_ptr];
          r.pages    = slot_pages[head_ptr];
          head_ptr = (head_ptr + 1) % DEPTH;
          job_count--;
          page_total -= int'(r.pages);
        end
        post_report(r);
      end
      OP_LIST: begin
        if (job_count == 0) begin
          r.status = STAT_EMPTY;
          post_report(r);
        end else begin
          for (k = 0; k < job_count; k++) begin
            s = (head_ptr + k) % DEPTH;
            r.status   = STAT_OK;
            r.position = 5'(k + 1);
            r.name     = slot_name[s];
            r.kind     = slot_kind[s];
            r.pages    = slot_pages[s];
            r.last     = (k + 1 == job_count);
            post_report(r);
          end
        end
      end
      OP_CLEAR: begin
        if (job_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status   = STAT_OK;
          job_count  = 0;
          page_total = 0;
          head_ptr   = 0;
        end
        post_report(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_job(input logic [2:0] op, input logic [63:0] nm,
                          input logic [31:0] kd, input logic [15:0] pg,
                          input logic [4:0] pos);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {3'b000, pos, pg, kd, nm};
    do @(posedge clk); while (!s_tready);
    apply_job_op(op, nm, kd, pg, pos);
  endtask

  function automatic logic [15:0] pick_pages();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic send_insert(input logic [15:0] pg);
    send_job(OP_INSERT, {$urandom, $urandom}, $urandom, pg, 5'($urandom));
  endtask

  task automatic send_plain(input logic [2:0] op);
    send_job(op, {$urandom, $urandom}, $urandom, 16'($urandom), 5'($urandom));
  endtask

  task automatic send_cancel(input logic [4:0] pos);
    send_job(OP_CANCEL, {$urandom, $urandom}, $urandom, 16'($urandom), pos);
  endtask

  // sink side: random stalls plus an optional long hold-off
  initial begin : sink_ready
    int hold_left;
    int stall_left;
    int hold_seen;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != hold_seen) begin
        hold_left = hold_request;
        hold_seen = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_tready   = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic check_field(input string fld, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fld, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    job_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result item: status %0d", m_tuser);
        error_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("status",         64'(want.status),   64'(m_tuser));
        check_field("entry_position", 64'(want.position), 64'(m_tdata[4:0]));
        check_field("out_job_name",   want.name,          m_tdata[68:5]);
        check_field("out_job_type",   64'(want.kind),     64'(m_tdata[100:69]));
        check_field("out_page_count", 64'(want.pages),    64'(m_tdata[116:101]));
        check_field("queue_length",   64'(want.length),   64'(m_tdata[121:117]));
        check_field("pages_total",    64'(want.total),    64'(m_tdata[141:122]));
        check_field("last_result",    64'(want.last),     64'(m_tlast));
      end
    end
  end

  task automatic test_empty_queue();
    send_plain(OP_CONSUME);
    send_cancel(5'd1);
    send_plain(OP_CLEAR);
    send_plain(OP_LIST);
    send_plain(OP_SPARE_LO);
    send_plain(OP_SPARE_HI);
  endtask

  task automatic test_fill_extremes();
    int i;
    send_insert(16'h0000);
    send_job(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F);
    send_job(OP_INSERT, 64'h0, 32'h0, 16'hFFFF, 5'h00);
    for (i = 2; i < DEPTH; i++) begin
      send_insert(16'hFFFF);
    end
    send_insert(16'h1234);
    send_insert(16'h0000);
    send_plain(OP_LIST);
  endtask

  task automatic test_cancel_positions();
    send_cancel(5'd0);
    send_cancel(5'd31);
    send_cancel(5'd17);
    send_cancel(5'd16);
    send_cancel(5'd1);
    send_cancel(5'd7);
    send_plain(OP_CONSUME);
    send_plain(OP_LIST);
    send_plain(OP_CLEAR);
    send_plain(OP_CLEAR);
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int fill_bias;
    int pick;
    fill_bias = 50;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 40 == 0) begin
        fill_bias = $urandom_range(25, 85);
      end
      if ($urandom_range(0, 99) < fill_bias) begin
        send_insert(pick_pages());
        sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          if (job_count > 0 && $urandom_range(0, 4) != 0) begin
            send_cancel(5'($urandom_range(1, job_count)));
          end else begin
            send_cancel(5'($urandom_range(0, 31)));
          end
          sent++;
        end else if (pick < 65) begin
          send_plain(OP_CONSUME);
          sent++;
        end else if (pick < 85) begin
          send_plain(OP_LIST);
          sent++;
        end else if (pick < 93) begin
          send_plain(OP_CLEAR);
          sent++;
        end else begin
          send_plain(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
        end
      end
    end
  endtask

  // sink holds off while the source keeps offering items
  task automatic test_backpressure();
    int i;
    hold_request = 150;
    for (i = 0; i < 18; i++) begin
      send_insert(16'($urandom_range(1, 65535)));
    end
    send_plain(OP_LIST);
    send_cancel(5'($urandom_range(1, 16)));
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    head_ptr     = 0;
    job_count    = 0;
    page_total   = 0;
    error_count  = 0;
    hold_request = 0;
    idle_on      = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    test_fill_extremes();
    test_cancel_positions();
    test_random_traffic(260);
    test_backpressure();
    idle_on = 1'b0;
    test_random_traffic(50);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("job_queue_with_cancel_unit regression: pass");
    end else begin
      $display("job_queue_with_cancel_unit regression: fail");
    end
    $finish;
  end

endmodule

/* job_queue_with_cancel_unit.f */
+incdir+rtl/core
rtl/core/jqc_pkg.sv
rtl/core/jqc_ram.sv
rtl/core/job_queue_with_cancel_unit.sv
tb/sv/tb_top.sv
